// ===== rtl/core/plloc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL output rate calculator package
// Shared widths, codes and stage types for the rate calculator.
// ----------------------------------------------------------------------------
package plloc_pkg;

    localparam int REF_W   = 27;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int RATE_W  = 45;
    localparam int STAT_W  = 2;
    localparam int DVD_W   = 39;   // full dividend, reference * intp * sdiv plus fraction
    localparam int REM_W   = 28;   // divisor and remainder width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [WORD_W-1:0] FRAC_HALF = 32'h8000_0000;
    localparam logic [3:0]        HS_SEL_CODE = 4'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_RUN    = 2'd0,
        ST_STOP   = 2'd1,
        ST_BYPASS = 2'd2,
        ST_ZERO   = 2'd3
    } plloc_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_PRESENT  = 3'd0,
        CFG_POST_PRESENT = 3'd1,
        CFG_PRE_EXT      = 3'd2,
        CFG_POST_EXT     = 3'd3,
        CFG_SIGNED_FRAC  = 3'd4,
        CFG_FIXED_DIV    = 3'd5,
        CFG_REVISION     = 3'd6
    } plloc_cfg_idx_t;

    typedef struct packed {
        logic             pre_present;
        logic             post_present;
        logic             pre_ext;
        logic             post_ext;
        logic             signed_frac;
        logic [BYTE_W-1:0] fixed_div;
        logic             revision;
    } plloc_cfg_t;

    // One request in flight through the divider chain.
    typedef struct packed {
        logic [DVD_W-1:0] dq;      // dividend bits still to go, quotient bits shifted in
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dsr;
        plloc_status_t    status;
        logic             dbl;
    } plloc_div_t;

    function automatic logic [BYTE_W:0] scaler(input logic present, input logic ext,
                                                input logic [BYTE_W-1:0] raw);
        logic [BYTE_W:0] res;
        begin
            res = {{BYTE_W{1'b0}}, 1'b1};
            if (present)
            begin
                if (ext)
                    res = {5'd0, raw[7:4]} + 9'd1;
                else
                    res = {1'b0, raw};
            end
            return res;
        end
    endfunction

endpackage

// ===== rtl/core/plloc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one PLL register snapshot per request.
// ----------------------------------------------------------------------------
interface plloc_in_if;
    logic        valid;
    logic        ready;
    logic [26:0] reference_rate;
    logic [31:0] control_word;
    logic [31:0] control2_word;
    logic [31:0] fraction_word;
    logic [7:0]  pre_scaler_raw;
    logic [7:0]  post_scaler_raw;

    modport source (output valid, reference_rate, control_word, control2_word,
                    fraction_word, pre_scaler_raw, post_scaler_raw, input ready);
    modport sink (input valid, reference_rate, control_word, control2_word,
                  fraction_word, pre_scaler_raw, post_scaler_raw, output ready);
endinterface

// ===== rtl/core/plloc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying the output rate and status per request.
// ----------------------------------------------------------------------------
interface plloc_out_if;
    logic        valid;
    logic        ready;
    logic [44:0] output_rate;
    logic [1:0]  status;

    modport source (output valid, output_rate, status, input ready);
    modport sink (input valid, output_rate, status, output ready);
endinterface

// ===== rtl/core/plloc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Decodes the register snapshot and forms dividend and divisor in three
// registered stages: two of multiplies, then the fraction adjustment.
// ----------------------------------------------------------------------------
module plloc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  plloc_pkg::plloc_cfg_t cfg,
    input  logic [26:0]          reference_rate,
    input  logic [31:0]          control_word,
    input  logic [31:0]          control2_word,
    input  logic [31:0]          fraction_word,
    input  logic [7:0]           pre_scaler_raw,
    input  logic [7:0]           post_scaler_raw,
    output logic                 out_valid,
    output plloc_pkg::plloc_div_t out_d
);
    import plloc_pkg::*;

    // Stage A registers
    logic              a_valid_reg;
    logic [34:0]       a_base_reg, a_base_next;
    logic [58:0]       a_fprod_reg, a_fprod_next;
    logic [26:0]       a_ref_reg;
    logic [4:0]        a_sdiv_reg;
    logic              a_fen_reg, a_fneg_reg, a_byp_reg, a_dbl_reg;
    logic [15:0]       a_pp_reg, a_pp_next;
    logic [12:0]       a_sf_reg, a_sf_next;
    plloc_status_t     a_stat_reg, a_stat_next;

    // Stage B registers
    logic              b_valid_reg;
    logic [37:0]       b_base_reg, b_base_next;
    logic [30:0]       b_fterm_reg, b_fterm_next;
    logic [63:0]       b_fprod_full;
    logic [REM_W-1:0]  b_dsr_reg, b_dsr_next;
    logic              b_fen_reg, b_fneg_reg, b_dbl_reg;
    plloc_status_t     b_stat_reg;

    // Stage C registers
    logic              c_valid_reg;
    plloc_div_t        c_d_reg, c_d_next;

    logic [BYTE_W:0]   pre_v, post_v;
    logic [7:0]        intp_v;
    logic [4:0]        sdiv_v, sout_v;
    logic [31:0]       frac_v;
    logic              byp_v, fneg_v;

    // Decode and first products.
    always_comb
    begin
        pre_v  = scaler(cfg.pre_present, cfg.pre_ext, pre_scaler_raw);
        post_v = scaler(cfg.post_present, cfg.post_ext, post_scaler_raw);
        intp_v = {1'b0, control_word[30:24]} + 8'd1;
        sdiv_v = {1'b0, control_word[15:12]} + 5'd1;
        sout_v = {1'b0, control_word[19:16]} + 5'd1;
        byp_v  = control_word[2] | control_word[21];
        fneg_v = cfg.signed_frac & fraction_word[31];
        if (!cfg.signed_frac)
            frac_v = fraction_word;
        else if (fraction_word[31])
            frac_v = FRAC_HALF - {1'b0, fraction_word[30:0]};
        else
            frac_v = {1'b0, fraction_word[30:0]};
        a_base_next  = 35'(reference_rate * intp_v);
        a_fprod_next = 59'(reference_rate * frac_v);
        a_pp_next    = 16'(pre_v[7:0] * post_v[7:0]);
        a_sf_next    = 13'(sout_v * cfg.fixed_div);
        if (control_word[5] | control_word[6])
            a_stat_next = ST_STOP;
        else if (pre_v == '0 || post_v == '0 || (!byp_v && cfg.fixed_div == '0))
            a_stat_next = ST_ZERO;
        else if (byp_v)
            a_stat_next = ST_BYPASS;
        else
            a_stat_next = ST_RUN;
    end

    // Second products.
    always_comb
    begin
        b_fprod_full = 64'(a_fprod_reg * a_sdiv_reg);
        b_fterm_next = b_fprod_full[62:32];
        if (a_byp_reg)
        begin
            b_base_next = {11'd0, a_ref_reg};
            b_dsr_next  = {12'd0, a_pp_reg};
        end
        else
        begin
            b_base_next = 38'(a_base_reg * a_sdiv_reg);
            b_dsr_next  = 28'(a_pp_reg * a_sf_reg);
        end
    end

    // Fraction adjustment and divisor guard.
    always_comb
    begin
        c_d_next.rem    = '0;
        c_d_next.status = b_stat_reg;
        c_d_next.dbl    = b_dbl_reg;
        c_d_next.dsr    = (b_stat_reg == ST_STOP || b_stat_reg == ST_ZERO) ? 28'd1 : b_dsr_reg;
        if (!b_fen_reg)
            c_d_next.dq = {1'b0, b_base_reg};
        else if (b_fneg_reg)
            c_d_next.dq = {1'b0, b_base_reg} - {8'd0, b_fterm_reg};
        else
            c_d_next.dq = {1'b0, b_base_reg} + {8'd0, b_fterm_reg};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_base_reg  <= a_base_next;
            a_fprod_reg <= a_fprod_next;
            a_ref_reg   <= reference_rate;
            a_sdiv_reg  <= sdiv_v;
            a_fen_reg   <= control_word[3] & ~byp_v;
            a_fneg_reg  <= fneg_v;
            a_byp_reg   <= byp_v;
            a_dbl_reg   <= cfg.revision ? control2_word[9]
                                        : (control2_word[7:4] == HS_SEL_CODE);
            a_pp_reg    <= a_pp_next;
            a_sf_reg    <= a_sf_next;
            a_stat_reg  <= a_stat_next;
            b_base_reg  <= b_base_next;
            b_fterm_reg <= b_fterm_next;
            b_dsr_reg   <= b_dsr_next;
            b_fen_reg   <= a_fen_reg;
            b_fneg_reg  <= a_fneg_reg;
            b_dbl_reg   <= a_dbl_reg;
            b_stat_reg  <= a_stat_reg;
            c_d_reg     <= c_d_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_d     = c_d_reg;

endmodule

// ===== rtl/core/plloc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: takes the next dividend bit into the
// remainder and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module plloc_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  plloc_pkg::plloc_div_t in_d,
    output logic                 out_valid,
    output plloc_pkg::plloc_div_t out_d
);
    import plloc_pkg::*;

    logic              valid_reg;
    plloc_div_t        d_reg, d_next;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;

    // Compare and subtract.
    always_comb
    begin
        trial  = {in_d.rem, in_d.dq[DVD_W-1]};
        diff   = trial - {1'b0, in_d.dsr};
        ge     = trial >= {1'b0, in_d.dsr};
        d_next = in_d;
        d_next.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        d_next.dq  = {in_d.dq[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;

endmodule

// ===== rtl/core/pll_output_rate_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL output rate calculator
// Gives a fractional-N PLL's output frequency from a register snapshot.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Carries
//  in_ch    | sink      | reference rate and PLL register words
//  out_ch   | source    | output rate in Hz and status
//  cfg_*    | write     | configuration registers by index
//
// A new request may enter every cycle the pipeline moves; each passes three
// front stages, then one chain cell per quotient bit of the 39-bit dividend.
// Reset clears only the valid flags and the configuration registers.
// When the result at the end of the chain is not taken, the whole pipeline
// holds and in_ch.ready drops.
// ----------------------------------------------------------------------------
module pll_output_rate_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    plloc_in_if.sink                      in_ch,
    plloc_out_if.source                   out_ch,
    input  logic                          cfg_we,
    input  logic [plloc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plloc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import plloc_pkg::*;

    plloc_cfg_t  cfg_reg;
    logic        en;
    logic        chain_valid [DVD_W+1];
    plloc_div_t  chain_d     [DVD_W+1];
    plloc_div_t  last_d;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pre_present: 1'b0, post_present: 1'b0, pre_ext: 1'b0,
                         post_ext: 1'b0, signed_frac: 1'b0, fixed_div: 8'd1,
                         revision: 1'b0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRE_PRESENT:  cfg_reg.pre_present  <= cfg_data[0];
                CFG_POST_PRESENT: cfg_reg.post_present <= cfg_data[0];
                CFG_PRE_EXT:      cfg_reg.pre_ext      <= cfg_data[0];
                CFG_POST_EXT:     cfg_reg.post_ext     <= cfg_data[0];
                CFG_SIGNED_FRAC:  cfg_reg.signed_frac  <= cfg_data[0];
                CFG_FIXED_DIV:    cfg_reg.fixed_div    <= cfg_data;
                CFG_REVISION:     cfg_reg.revision     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // The pipeline moves whenever the final stage is empty or being taken.
    assign en          = ~chain_valid[DVD_W] | out_ch.ready;
    assign in_ch.ready = en;

    plloc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (in_ch.valid),
        .cfg             (cfg_reg),
        .reference_rate  (in_ch.reference_rate),
        .control_word    (in_ch.control_word),
        .control2_word   (in_ch.control2_word),
        .fraction_word   (in_ch.fraction_word),
        .pre_scaler_raw  (in_ch.pre_scaler_raw),
        .post_scaler_raw (in_ch.post_scaler_raw),
        .out_valid       (chain_valid[0]),
        .out_d           (chain_d[0])
    );

    // Chain of division cells, one quotient bit each.
    for (genvar i = 0; i < DVD_W; i++)
    begin : g_cell
        plloc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_d      (chain_d[i]),
            .out_valid (chain_valid[i+1]),
            .out_d     (chain_d[i+1])
        );
    end

    // Final scaling of the quotient.
    always_comb
    begin
        last_d = chain_d[DVD_W];
        case (last_d.status)
            ST_RUN:    out_ch.output_rate = last_d.dbl ? RATE_W'({last_d.dq, 1'b0})
                                                       : RATE_W'(last_d.dq);
            ST_BYPASS: out_ch.output_rate = RATE_W'(last_d.dq);
            default:   out_ch.output_rate = '0;
        endcase
    end

    assign out_ch.valid  = chain_valid[DVD_W];
    assign out_ch.status = last_d.status;

endmodule
